// ===== src/page_run_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// page_run_allocator_assert.svh
// Assertion macros shared by the page run allocator checkers.
// ----------------------------------------------------------------------------
`ifndef PAGE_RUN_ALLOCATOR_ASSERT_SVH
`define PAGE_RUN_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define PRA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define PRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Types, constants and helpers for the page run allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

    // Heap geometry
    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int LINK_W     = IDX_W + 1;
    localparam int COUNT_W    = 11;
    localparam int ADDR_W     = 32;
    localparam int SUM_W      = ((LINK_W > COUNT_W) ? LINK_W : COUNT_W) + 1;

    // End-of-list / empty marker
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(NUM_PAGES);

    localparam logic [ADDR_W-1:0] HEAP_BASE_RST = 32'hC000_0000;

    // Request type codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED  = 3'd0,
        ST_BUMP    = 3'd1,
        ST_FREED   = 3'd2,
        ST_IGNORED = 3'd3,
        ST_NOSPACE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_WALK,
        S_BUMP,
        S_LINK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               req_type;
        logic [COUNT_W-1:0] page_count;
        logic [ADDR_W-1:0]  page_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] run_address;
        logic [IDX_W-1:0]  run_index;
        status_t           status;
    } rsp_t;

    // Controls for the link, length and on-list memories
    typedef struct packed {
        logic               rd_en;
        logic [IDX_W-1:0]   rd_addr;
        logic               link_we;
        logic [IDX_W-1:0]   link_waddr;
        logic [LINK_W-1:0]  link_wdata;
        logic               len_we;
        logic [IDX_W-1:0]   len_waddr;
        logic [COUNT_W-1:0] len_wdata;
        logic               on_we;
        logic [IDX_W-1:0]   on_waddr;
        logic               on_wdata;
    } ram_ctl_t;

    // Byte address of a page index
    function automatic logic [ADDR_W-1:0] page_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [IDX_W-1:0]  idx);
        return base + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

endpackage

// ===== src/pra_ram.sv =====
// ----------------------------------------------------------------------------
// pra_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pra_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // Read port, registered output
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pra_walker.sv =====
// ----------------------------------------------------------------------------
// pra_walker
// Request sequencer: on-list clear pass, list walk, unlink, bump cut and
// tail append.
// ----------------------------------------------------------------------------
module pra_walker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  pra_pkg::req_t                  req,
    input  logic [pra_pkg::ADDR_W-1:0]     heap_base,
    output pra_pkg::ram_ctl_t              ram_ctl,
    input  logic [pra_pkg::LINK_W-1:0]     link_rdata,
    input  logic [pra_pkg::COUNT_W-1:0]    len_rdata,
    input  logic                           on_rdata,
    output logic                           res_valid,
    input  logic                           res_ready,
    output pra_pkg::rsp_t                  res
);

    pra_pkg::state_t state_reg, state_next;

    // List and bump state
    logic [pra_pkg::LINK_W-1:0]  head_reg, head_next;
    logic [pra_pkg::LINK_W-1:0]  tail_reg, tail_next;
    logic [pra_pkg::LINK_W-1:0]  free_cnt_reg, free_cnt_next;
    logic [pra_pkg::LINK_W-1:0]  bump_reg, bump_next;
    logic [pra_pkg::IDX_W-1:0]   clr_reg, clr_next;

    // Latched item and walk pointers
    logic                        type_reg, type_next;
    logic [pra_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [pra_pkg::ADDR_W-1:0]  addr_reg, addr_next;
    logic [pra_pkg::LINK_W-1:0]  cur_reg, cur_next;
    logic [pra_pkg::LINK_W-1:0]  prev_reg, prev_next;
    logic [pra_pkg::LINK_W-1:0]  steps_reg, steps_next;
    pra_pkg::rsp_t               res_reg, res_next;

    // Datapath terms
    logic [pra_pkg::ADDR_W-1:0]  free_off;
    logic [pra_pkg::ADDR_W-1:0]  free_page;
    logic                        free_bad;
    logic [pra_pkg::IDX_W-1:0]   free_idx;
    logic                        hit;
    logic [pra_pkg::LINK_W-1:0]  steps_inc;
    logic                        walk_stop;
    logic [pra_pkg::SUM_W-1:0]   bump_sum;
    logic                        bump_full;

    assign free_off  = addr_reg - heap_base;
    assign free_page = free_off >> pra_pkg::PAGE_SHIFT;
    assign free_bad  = (addr_reg == '0) ||
                       (free_page >= pra_pkg::ADDR_W'(pra_pkg::NUM_PAGES));
    assign free_idx  = free_page[pra_pkg::IDX_W-1:0];

    assign hit       = (len_rdata == count_reg);
    assign steps_inc = steps_reg + pra_pkg::LINK_W'(1);
    assign walk_stop = (link_rdata >= pra_pkg::LINK_NULL) ||
                       (steps_inc >= pra_pkg::LINK_NULL);

    assign bump_sum  = pra_pkg::SUM_W'(bump_reg) + pra_pkg::SUM_W'(count_reg);
    assign bump_full = (bump_sum > pra_pkg::SUM_W'(pra_pkg::NUM_PAGES));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pra_pkg::S_CLEAR:
            begin
                if (clr_reg == pra_pkg::IDX_W'(pra_pkg::NUM_PAGES - 1))
                begin
                    state_next = pra_pkg::S_IDLE;
                end
            end
            pra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = pra_pkg::S_DECODE;
                end
            end
            pra_pkg::S_DECODE:
            begin
                if (count_reg == '0)
                begin
                    state_next = pra_pkg::S_DONE;
                end
                else if (type_reg == pra_pkg::REQ_ALLOC)
                begin
                    state_next = (free_cnt_reg == '0) ? pra_pkg::S_BUMP : pra_pkg::S_WALK;
                end
                else
                begin
                    state_next = free_bad ? pra_pkg::S_DONE : pra_pkg::S_CHECK;
                end
            end
            pra_pkg::S_CHECK:
            begin
                state_next = on_rdata ? pra_pkg::S_DONE : pra_pkg::S_LINK;
            end
            pra_pkg::S_WALK:
            begin
                if (hit)
                begin
                    state_next = pra_pkg::S_DONE;
                end
                else if (walk_stop)
                begin
                    state_next = pra_pkg::S_BUMP;
                end
            end
            pra_pkg::S_BUMP:
            begin
                state_next = pra_pkg::S_DONE;
            end
            pra_pkg::S_LINK:
            begin
                state_next = pra_pkg::S_DONE;
            end
            pra_pkg::S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = pra_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pra_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and handshake outputs
    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        free_cnt_next = free_cnt_reg;
        bump_next     = bump_reg;
        clr_next      = clr_reg;
        type_next     = type_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        steps_next    = steps_reg;
        res_next      = res_reg;
        ram_ctl       = '0;
        req_ready     = (state_reg == pra_pkg::S_IDLE);
        res_valid     = (state_reg == pra_pkg::S_DONE);

        unique case (state_reg)
            pra_pkg::S_CLEAR:
            begin
                // Mark every page as off the list after reset
                ram_ctl.on_we    = 1'b1;
                ram_ctl.on_waddr = clr_reg;
                ram_ctl.on_wdata = 1'b0;
                clr_next         = clr_reg + pra_pkg::IDX_W'(1);
            end
            pra_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    type_next  = req.req_type;
                    count_next = req.page_count;
                    addr_next  = req.page_address;
                end
            end
            pra_pkg::S_DECODE:
            begin
                if (count_reg == '0)
                begin
                    res_next = '{run_address: '0, run_index: '0,
                                 status: pra_pkg::ST_IGNORED};
                end
                else if (type_reg == pra_pkg::REQ_ALLOC)
                begin
                    // Fetch the head entry to start the walk
                    if (free_cnt_reg != '0)
                    begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = head_reg[pra_pkg::IDX_W-1:0];
                        cur_next        = head_reg;
                        prev_next       = pra_pkg::LINK_NULL;
                        steps_next      = '0;
                    end
                end
                else if (free_bad)
                begin
                    res_next = '{run_address: '0, run_index: '0,
                                 status: pra_pkg::ST_IGNORED};
                end
                else
                begin
                    // Look up whether the run is already on the list
                    ram_ctl.rd_en   = 1'b1;
                    ram_ctl.rd_addr = free_idx;
                    cur_next        = pra_pkg::LINK_W'(free_idx);
                end
            end
            pra_pkg::S_CHECK:
            begin
                if (on_rdata)
                begin
                    // Double free: dropped
                    res_next = '{run_address: '0, run_index: '0,
                                 status: pra_pkg::ST_IGNORED};
                end
                else
                begin
                    // New tail entry: length as given, no successor
                    ram_ctl.len_we     = 1'b1;
                    ram_ctl.len_waddr  = cur_reg[pra_pkg::IDX_W-1:0];
                    ram_ctl.len_wdata  = count_reg;
                    ram_ctl.link_we    = 1'b1;
                    ram_ctl.link_waddr = cur_reg[pra_pkg::IDX_W-1:0];
                    ram_ctl.link_wdata = pra_pkg::LINK_NULL;
                    ram_ctl.on_we      = 1'b1;
                    ram_ctl.on_waddr   = cur_reg[pra_pkg::IDX_W-1:0];
                    ram_ctl.on_wdata   = 1'b1;
                end
            end
            pra_pkg::S_LINK:
            begin
                // Hook the new run behind the old tail
                if (tail_reg >= pra_pkg::LINK_NULL)
                begin
                    head_next = cur_reg;
                end
                else
                begin
                    ram_ctl.link_we    = 1'b1;
                    ram_ctl.link_waddr = tail_reg[pra_pkg::IDX_W-1:0];
                    ram_ctl.link_wdata = cur_reg;
                end
                tail_next     = cur_reg;
                free_cnt_next = free_cnt_reg + pra_pkg::LINK_W'(1);
                res_next      = '{run_address: '0,
                                  run_index: cur_reg[pra_pkg::IDX_W-1:0],
                                  status: pra_pkg::ST_FREED};
            end
            pra_pkg::S_WALK:
            begin
                if (hit)
                begin
                    // Unlink the matching run
                    if (prev_reg >= pra_pkg::LINK_NULL)
                    begin
                        head_next = link_rdata;
                    end
                    else
                    begin
                        ram_ctl.link_we    = 1'b1;
                        ram_ctl.link_waddr = prev_reg[pra_pkg::IDX_W-1:0];
                        ram_ctl.link_wdata = link_rdata;
                    end
                    ram_ctl.on_we    = 1'b1;
                    ram_ctl.on_waddr = cur_reg[pra_pkg::IDX_W-1:0];
                    ram_ctl.on_wdata = 1'b0;
                    if (tail_reg == cur_reg)
                    begin
                        tail_next = prev_reg;
                    end
                    if (free_cnt_reg != '0)
                    begin
                        free_cnt_next = free_cnt_reg - pra_pkg::LINK_W'(1);
                    end
                    res_next = '{run_address: pra_pkg::page_addr(heap_base,
                                                   cur_reg[pra_pkg::IDX_W-1:0]),
                                 run_index: cur_reg[pra_pkg::IDX_W-1:0],
                                 status: pra_pkg::ST_REUSED};
                end
                else
                begin
                    // Step to the successor, fetching it unless the walk ends
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = steps_inc;
                    if (!walk_stop)
                    begin
                        ram_ctl.rd_en   = 1'b1;
                        ram_ctl.rd_addr = link_rdata[pra_pkg::IDX_W-1:0];
                    end
                end
            end
            pra_pkg::S_BUMP:
            begin
                if (bump_full)
                begin
                    res_next = '{run_address: '0, run_index: '0,
                                 status: pra_pkg::ST_NOSPACE};
                end
                else
                begin
                    bump_next = bump_sum[pra_pkg::LINK_W-1:0];
                    res_next  = '{run_address: pra_pkg::page_addr(heap_base,
                                                    bump_reg[pra_pkg::IDX_W-1:0]),
                                  run_index: bump_reg[pra_pkg::IDX_W-1:0],
                                  status: pra_pkg::ST_BUMP};
                end
            end
            pra_pkg::S_DONE:
            begin
                // Hold the result until the output stage takes it
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pra_pkg::S_CLEAR;
            head_reg     <= pra_pkg::LINK_NULL;
            tail_reg     <= pra_pkg::LINK_NULL;
            free_cnt_reg <= '0;
            bump_reg     <= '0;
            clr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_cnt_reg <= free_cnt_next;
            bump_reg     <= bump_next;
            clr_reg      <= clr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        count_reg <= count_next;
        addr_reg  <= addr_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== src/page_run_allocator.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator
// Allocates and frees runs of contiguous heap pages: exact-fit reuse from a
// free list, otherwise a bump cut; frees append at the list tail.
// ----------------------------------------------------------------------------
//  channel | direction | signals                     | payload
//  req     | in        | req_valid / req_ready       | req_type, page_count, page_address
//  rsp     | out       | rsp_valid / rsp_ready       | run_address, run_index, status
//  cfg     | in        | cfg_valid / cfg_ready       | heap_base (cfg_data)
//
//  One item at a time. An allocation walks the list until a hit or its end
//  (one list link read per cycle) and cuts from the bump index on no hit.
//  Results sit in an output register; the next item is taken while it waits.
//  Reset empties the list and clears the bump index, then a pass clears the
//  on-list memory with req_ready low. cfg_ready is always high.
// ----------------------------------------------------------------------------
module page_run_allocator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  pra_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output pra_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pra_pkg::ADDR_W-1:0] cfg_data
);

    logic [pra_pkg::ADDR_W-1:0]  heap_base_reg;
    pra_pkg::ram_ctl_t           ram_ctl;
    logic [pra_pkg::LINK_W-1:0]  link_rdata;
    logic [pra_pkg::COUNT_W-1:0] len_rdata;
    logic                        on_rdata;
    logic                        res_valid;
    logic                        res_ready;
    pra_pkg::rsp_t               res;
    logic                        out_valid_reg, out_valid_next;
    pra_pkg::rsp_t               out_data_reg, out_data_next;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= pra_pkg::HEAP_BASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            heap_base_reg <= cfg_data;
        end
    end

    // Link and length memories, indexed by first page of a run
    pra_ram #(
        .WIDTH (pra_pkg::LINK_W),
        .DEPTH (pra_pkg::NUM_PAGES)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_ctl.link_we),
        .wr_addr (ram_ctl.link_waddr),
        .wr_data (ram_ctl.link_wdata),
        .rd_en   (ram_ctl.rd_en),
        .rd_addr (ram_ctl.rd_addr),
        .rd_data (link_rdata)
    );

    pra_ram #(
        .WIDTH (pra_pkg::COUNT_W),
        .DEPTH (pra_pkg::NUM_PAGES)
    ) u_len_ram (
        .clk     (clk),
        .wr_en   (ram_ctl.len_we),
        .wr_addr (ram_ctl.len_waddr),
        .wr_data (ram_ctl.len_wdata),
        .rd_en   (ram_ctl.rd_en),
        .rd_addr (ram_ctl.rd_addr),
        .rd_data (len_rdata)
    );

    // On-list flag per first page, cleared by the pass after reset
    pra_ram #(
        .WIDTH (1),
        .DEPTH (pra_pkg::NUM_PAGES)
    ) u_on_ram (
        .clk     (clk),
        .wr_en   (ram_ctl.on_we),
        .wr_addr (ram_ctl.on_waddr),
        .wr_data (ram_ctl.on_wdata),
        .rd_en   (ram_ctl.rd_en),
        .rd_addr (ram_ctl.rd_addr),
        .rd_data (on_rdata)
    );

    // Sequencer
    pra_walker u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .heap_base  (heap_base_reg),
        .ram_ctl    (ram_ctl),
        .link_rdata (link_rdata),
        .len_rdata  (len_rdata),
        .on_rdata   (on_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || rsp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

// ===== src/pra_checker.sv =====
// ----------------------------------------------------------------------------
// pra_checker
// Port-level checks for the page run allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_run_allocator_assert.svh"

module pra_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pra_pkg::rsp_t rsp
);

    // One item in work at a time
    `PRA_ASSERT_NEXT(a_one_item, (req_valid && req_ready), !req_ready, "item taken while busy")

    // No result can appear the cycle after an item is taken
    `PRA_ASSERT_NEXT(a_no_instant_rsp, (req_valid && req_ready && !rsp_valid), !rsp_valid, "result too early")

    // A new result is loaded only while the request side is busy
    `PRA_ASSERT_SAME(a_rsp_from_busy, $rose(rsp_valid), !$past(req_ready), "result while idle")

    // Stalled result holds
    `PRA_ASSERT_NEXT(a_rsp_hold, (rsp_valid && !rsp_ready), (rsp_valid && $stable(rsp)), "result changed under stall")

    // Only allocations carry an address
    `PRA_ASSERT_SAME(a_addr_zero, (rsp_valid && (rsp.status == pra_pkg::ST_FREED || rsp.status == pra_pkg::ST_IGNORED || rsp.status == pra_pkg::ST_NOSPACE)), (rsp.run_address == '0), "address on non-allocation")

endmodule

bind page_run_allocator pra_checker u_pra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// ===== verif/page_run_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_checker
// Watches the request, result and register channels of the page run
// allocator, predicts each result from its own copy of the free list and
// bump index, and compares every field of each result in arrival order.
// ----------------------------------------------------------------------------
module page_run_allocator_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  pra_pkg::req_t              req,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  pra_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [pra_pkg::ADDR_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending
);

    import pra_pkg::*;

    // Predicted allocator state
    logic [LINK_W-1:0]  link_of   [NUM_PAGES];
    logic [COUNT_W-1:0] length_of [NUM_PAGES];
    bit                 listed    [NUM_PAGES];
    logic [LINK_W-1:0]  head;
    logic [LINK_W-1:0]  tail;
    logic [LINK_W-1:0]  bump;
    logic [ADDR_W-1:0]  heap_base;

    rsp_t due_results [$];
    rsp_t want;
    int   mismatch_count = 0;

    assign mismatches = mismatch_count;

    // Byte address of a page index under the current base, wrapping at 2^32
    function automatic logic [ADDR_W-1:0] run_base(input logic [IDX_W-1:0] slot);
        return heap_base + (ADDR_W'(slot) << PAGE_SHIFT);
    endfunction

    // Apply one request to the predicted state and return its result
    function automatic rsp_t serve_request(input req_t r);
        rsp_t              res;
        logic [LINK_W-1:0] prev;
        logic [LINK_W-1:0] cur;
        logic [ADDR_W-1:0] offset;
        logic [IDX_W-1:0]  slot;
        int                steps;
        res.run_address = '0;
        res.run_index   = '0;
        res.status      = ST_IGNORED;
        if (r.page_count == '0)
            return res;
        if (r.req_type == REQ_ALLOC)
        begin
            // first exact-length run on the list wins
            prev  = LINK_NULL;
            cur   = head;
            steps = 0;
            while (cur < NUM_PAGES && steps < NUM_PAGES)
            begin
                slot = cur[IDX_W-1:0];
                if (length_of[slot] == r.page_count)
                begin
                    if (prev == LINK_NULL)
                        head = link_of[slot];
                    else
                        link_of[prev[IDX_W-1:0]] = link_of[slot];
                    if (tail == cur)
                        tail = prev;
                    listed[slot]    = 1'b0;
                    res.run_address = run_base(slot);
                    res.run_index   = slot;
                    res.status      = ST_REUSED;
                    return res;
                end
                prev = cur;
                cur  = link_of[slot];
                steps++;
            end
            // no match: cut from the bump index, or report exhaustion
            if (int'(bump) + int'(r.page_count) > NUM_PAGES)
            begin
                res.status = ST_NOSPACE;
                return res;
            end
            slot            = bump[IDX_W-1:0];
            bump            = bump + r.page_count;
            res.run_address = run_base(slot);
            res.run_index   = slot;
            res.status      = ST_BUMP;
            return res;
        end
        // free: null, outside the heap and already-listed runs are dropped
        offset = (r.page_address - heap_base) >> PAGE_SHIFT;
        if (r.page_address == '0 || offset >= NUM_PAGES)
            return res;
        slot = offset[IDX_W-1:0];
        if (listed[slot])
            return res;
        length_of[slot] = r.page_count;
        link_of[slot]   = LINK_NULL;
        listed[slot]    = 1'b1;
        if (tail == LINK_NULL)
            head = LINK_W'(slot);
        else
            link_of[tail[IDX_W-1:0]] = LINK_W'(slot);
        tail          = LINK_W'(slot);
        res.run_index = slot;
        res.status    = ST_FREED;
        return res;
    endfunction

    task automatic flag(input string field, input logic [31:0] exp_val, act_val);
        mismatch_count++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val, act_val);
    endtask

    // Track handshakes: results are compared before the new item is queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head      = LINK_NULL;
            tail      = LINK_NULL;
            bump      = '0;
            heap_base = HEAP_BASE_RST;
            for (int i = 0; i < NUM_PAGES; i++)
                listed[i] = 1'b0;
            due_results.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                heap_base = cfg_data;
            if (rsp_valid && rsp_ready)
            begin
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, actual %h %h %h",
                             $time, rsp.run_address, rsp.run_index, rsp.status);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (rsp.run_address !== want.run_address)
                        flag("run_address", want.run_address, rsp.run_address);
                    if (rsp.run_index !== want.run_index)
                        flag("run_index", 32'(want.run_index), 32'(rsp.run_index));
                    if (rsp.status !== want.status)
                        flag("status", 32'(want.status), 32'(rsp.status));
                end
            end
            if (req_valid && req_ready)
                due_results.push_back(serve_request(req));
            pending <= due_results.size();
        end
    end

endmodule

// ===== verif/page_run_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator_tb
// Drives the page run allocator with directed and random allocate and free
// requests under several heap bases, with random stalls on both channels and
// one long result hold-off; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module page_run_allocator_tb;

    import pra_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 350;
    // worst case: every item walks a full list and waits out stalls, times four
    localparam int LIMIT_CYCLES = 4 * 2400 * (NUM_PAGES + 16) + 4 * HOLD_CYCLES;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] pages;
    } run_t;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_ready;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_ready;
    rsp_t              rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data;

    int mismatches;
    int pending;

    // Stimulus bookkeeping
    logic [ADDR_W-1:0]  base_now = HEAP_BASE_RST;
    logic [IDX_W-1:0]   last_freed = '0;
    run_t               held [$];
    logic [COUNT_W-1:0] sent_counts [$];
    run_t               got_run;
    bit                 quiet = 1'b0;
    bit                 hold_go = 1'b0;
    bit                 hold_done = 1'b0;
    int                 hold_left = 0;
    int                 cycles = 0;

    page_run_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    page_run_allocator_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL page_run_allocator");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off, none while quiet
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_go && !hold_done)
        begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // Collect allocated runs so later frees can hand them back.
    // Channels only change at rising edges, so the falling edge sees settled values.
    always @(negedge clk)
    begin
        if (rsp_valid && rsp_ready && sent_counts.size() > 0)
        begin
            got_run.idx   = rsp.run_index;
            got_run.pages = sent_counts.pop_front();
            if (rsp.status == ST_REUSED || rsp.status == ST_BUMP)
                held.push_back(got_run);
        end
        if (req_valid && req_ready)
            sent_counts.push_back(req.page_count);
    end

    function automatic logic [ADDR_W-1:0] page_at(input logic [IDX_W-1:0] idx);
        return base_now + (ADDR_W'(idx) << PAGE_SHIFT);
    endfunction

    function automatic req_t make_req(input logic kind, input logic [COUNT_W-1:0] pages,
                                      input logic [ADDR_W-1:0] addr);
        req_t r;
        r.req_type     = kind;
        r.page_count   = pages;
        r.page_address = addr;
        return r;
    endfunction

    // Offer one item, with an occasional gap before it
    task automatic send_item(input req_t r);
        int gap;
        if (!quiet && $urandom_range(99) < 6)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Wait until every accepted item has its result
    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        base_now = value;
    endtask

    // Random item: mostly allocations and frees of runs handed out earlier
    task automatic next_item(output req_t r, output bit useful);
        int pick;
        int k;
        useful = 1'b1;
        r      = '0;
        pick   = $urandom_range(99);
        if (pick >= 45 && pick < 85 && held.size() == 0)
            pick = 0;
        if (pick < 45)
        begin
            k = $urandom_range(99);
            r.req_type     = REQ_ALLOC;
            r.page_address = $urandom;
            if (k < 80)
                r.page_count = COUNT_W'($urandom_range(8, 1));
            else if (k < 95)
                r.page_count = COUNT_W'($urandom_range(64, 1));
            else
                r.page_count = COUNT_W'($urandom_range(NUM_PAGES, 1));
        end
        else if (pick < 85)
        begin
            // hand a run back, sometimes with another length or low bits set
            k = $urandom_range(held.size() - 1);
            r.req_type     = REQ_FREE;
            r.page_count   = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(NUM_PAGES, 1))
                                                      : held[k].pages;
            r.page_address = page_at(held[k].idx)
                             + ($urandom_range(1) ? $urandom_range(4095) : 0);
            last_freed = held[k].idx;
            held.delete(k);
        end
        else if (pick < 90)
        begin
            // free the last run again
            r.req_type     = REQ_FREE;
            r.page_count   = COUNT_W'($urandom_range(8, 1));
            r.page_address = page_at(last_freed);
        end
        else if (pick < 97)
        begin
            // stray free: anywhere in the address space, or a random heap page
            useful     = 1'b0;
            r.req_type = REQ_FREE;
            if ($urandom_range(1))
            begin
                r.page_count   = COUNT_W'($urandom_range(NUM_PAGES, 1));
                r.page_address = $urandom;
            end
            else
            begin
                r.page_count   = COUNT_W'($urandom_range(16, 1));
                r.page_address = page_at(IDX_W'($urandom_range(NUM_PAGES - 1)));
            end
        end
        else
        begin
            useful         = 1'b0;
            r.req_type     = 1'($urandom_range(1));
            r.page_count   = '0;
            r.page_address = $urandom;
        end
    endtask

    task automatic run_phase(input int phase);
        req_t r;
        bit   useful;
        int   done;
        done = 0;
        while (done < PHASE_ITEMS)
        begin
            if (phase == 1 && done == 60)
                hold_go <= 1'b1;
            if (phase == 2)
                quiet <= (done >= 50 && done < 250);
            next_item(r, useful);
            send_item(r);
            if (useful)
                done++;
        end
        req_valid <= 1'b0;
    endtask

    // Main sequence
    initial
    begin
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        rsp_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        write_base(HEAP_BASE_RST);

        // zero counts
        send_item(make_req(REQ_ALLOC, COUNT_W'(0), '0));
        send_item(make_req(REQ_FREE, COUNT_W'(0), page_at(IDX_W'(3))));
        // bump cuts, then a full-heap request that no longer fits
        send_item(make_req(REQ_ALLOC, COUNT_W'(1), 32'hFFFF_FFFF));
        send_item(make_req(REQ_ALLOC, COUNT_W'(5), '0));
        send_item(make_req(REQ_ALLOC, COUNT_W'(NUM_PAGES), '0));
        // null, below the heap, one page past the end
        send_item(make_req(REQ_FREE, COUNT_W'(3), '0));
        send_item(make_req(REQ_FREE, COUNT_W'(3), base_now - 32'h1000));
        send_item(make_req(REQ_FREE, COUNT_W'(3), base_now + (NUM_PAGES << PAGE_SHIFT)));
        // free with low bits set, then the same run again
        send_item(make_req(REQ_FREE, COUNT_W'(5), page_at(IDX_W'(1)) + 32'hFFF));
        send_item(make_req(REQ_FREE, COUNT_W'(5), page_at(IDX_W'(1))));
        send_item(make_req(REQ_FREE, COUNT_W'(1), page_at(IDX_W'(0))));
        // never-allocated last page with the largest length
        send_item(make_req(REQ_FREE, COUNT_W'(NUM_PAGES), page_at(IDX_W'(NUM_PAGES - 1))));
        // hits in the middle, at the tail, at the head
        send_item(make_req(REQ_ALLOC, COUNT_W'(1), '0));
        send_item(make_req(REQ_ALLOC, COUNT_W'(NUM_PAGES), '0));
        send_item(make_req(REQ_ALLOC, COUNT_W'(5), '0));
        send_item(make_req(REQ_ALLOC, COUNT_W'(7), '0));
        send_item(make_req(REQ_FREE, COUNT_W'(7), page_at(IDX_W'(6))));
        send_item(make_req(REQ_FREE, COUNT_W'(2), page_at(IDX_W'(20))));
        // full walk with no match, then a tail hit, then the head
        send_item(make_req(REQ_ALLOC, COUNT_W'(3), '0));
        send_item(make_req(REQ_ALLOC, COUNT_W'(2), '0));
        send_item(make_req(REQ_FREE, COUNT_W'(NUM_PAGES), 32'hFFFF_FFFF));
        send_item(make_req(REQ_ALLOC, COUNT_W'(7), 32'hFFFF_FFFF));
        req_valid <= 1'b0;

        write_base(32'h0000_0000);
        run_phase(1);
        write_base(32'hFFFF_F000);
        run_phase(2);
        write_base(32'hFFFF_FFFF);
        run_phase(3);
        write_base($urandom & 32'hFFFF_F000);
        run_phase(4);

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASS page_run_allocator");
        else
            $display("FAIL page_run_allocator");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/pra_pkg.sv
src/pra_ram.sv
src/pra_walker.sv
src/page_run_allocator.sv
src/pra_checker.sv
verif/page_run_allocator_checker.sv
verif/page_run_allocator_tb.sv
